/* sv/mp2d_pkg.sv */
// mp2d_pkg: shared types, constants and window arithmetic for the max pool block.
// Used by every module of max_pool_2d_stream; depends on nothing.

package mp2d_pkg;

   // Internal axis arithmetic width: covers planes up to 4096 plus padding and stride.
   localparam int AXIS_W    = 14;
   localparam int KERN_W    = 5;
   localparam int STEP_W    = 4;
   localparam int PAD_W     = 3;
   localparam int SEQ_W     = 6;
   localparam int OUT_IDX_W = 11;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 11;

   localparam int DEF_MAX_COLS    = 1024;
   localparam int DEF_MAX_ROWS    = 1024;
   localparam int DEF_MAX_KERNEL  = 8;
   localparam int DEF_SAMPLE_BITS = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_IN_ROWS     = 4'd0,
      CFG_IN_COLS     = 4'd1,
      CFG_KERNEL_ROWS = 4'd2,
      CFG_KERNEL_COLS = 4'd3,
      CFG_STEP_ROWS   = 4'd4,
      CFG_STEP_COLS   = 4'd5,
      CFG_PAD_ROWS    = 4'd6,
      CFG_PAD_COLS    = 4'd7
   } cfg_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SETUP,
      BK_READ,
      BK_DRAIN,
      BK_FINISH
   } back_state_type;

   // Effective (clamped) settings of one axis.
   typedef struct packed {
      logic [AXIS_W-1:0] n;
      logic [KERN_W-1:0] k;
      logic [STEP_W-1:0] s;
      logic [PAD_W-1:0]  p;
   } axis_type;

   // One request's run of windows, handed from front to back.
   typedef struct packed {
      logic [AXIS_W-1:0] ro;
      logic [AXIS_W-1:0] rbeg;
      logic              row_all;
      logic [AXIS_W-1:0] co;
      logic [AXIS_W-1:0] cbeg;
      logic              col_all;
      logic [SEQ_W-1:0]  seq;
      logic [SEQ_W-1:0]  base;
   } task_type;

   // Unclamped last index of the window starting at padded position beg.
   function automatic logic [AXIS_W-1:0] win_end(axis_type a, logic [AXIS_W-1:0] beg);
      win_end = beg + AXIS_W'(a.k) - AXIS_W'(1) - AXIS_W'(a.p);
   endfunction

   // Window fits inside the padded axis.
   function automatic logic win_ok(axis_type a, logic [AXIS_W-1:0] beg);
      logic [AXIS_W:0] lhs;
      logic [AXIS_W:0] span;
      lhs  = {1'b0, beg} + (AXIS_W+1)'(a.k);
      span = {1'b0, a.n} + (AXIS_W+1)'({a.p, 1'b0});
      win_ok = lhs <= span;
   endfunction

   function automatic logic [AXIS_W-1:0] win_first(axis_type a, logic [AXIS_W-1:0] beg);
      win_first = (beg >= AXIS_W'(a.p)) ? beg - AXIS_W'(a.p) : '0;
   endfunction

   function automatic logic [AXIS_W-1:0] win_last(axis_type a, logic [AXIS_W-1:0] beg);
      logic [AXIS_W-1:0] e;
      e = win_end(a, beg);
      win_last = (e > a.n - AXIS_W'(1)) ? a.n - AXIS_W'(1) : e;
   endfunction

endpackage

/* sv/max_pool_2d_stream.sv */
// max_pool_2d_stream: 2-D max pooling over raster-ordered channel planes.
// Channels: req_* takes one sample per request; rsp_* gives one window maximum per
// request with its output row and column; csr_* writes the eight settings by index.
// Any settings write restarts the plane at row 0, column 0; write only while idle.
// Flow: a sample that completes no window needs no back-end work. For each result the
// back end passes through its setup, read, drain and finish states (fewer reads where
// padding clips the window), after its idle state when a run starts from idle; it reads
// the line store through its single read port one element per cycle. A four-deep run
// queue lets the front keep accepting while the back works, until the queue is full or
// the front would overwrite a row still pending (it then holds req_tready low).
// A completing sample's run passes the run queue and those back-end states to rsp_*.
// Reset: position and queues clear, settings return to defaults; the line store is
// not cleared, no pass is needed.
// rsp stall: the result register holds; the back end waits and the queue fills,
// then req_tready drops. Depends on mp2d_pkg and all mp2d_* modules.

module max_pool_2d_stream import mp2d_pkg::*; #(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS,
   parameter int MAX_KERNEL  = DEF_MAX_KERNEL,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int REQ_W = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((SAMPLE_BITS + 2 * OUT_IDX_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // sample
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // max_value, out_row, out_col
   output logic                  rsp_tlast,   // last_of_run
   output logic                  rsp_tuser,   // plane_done
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int SLOT_BITS = $clog2(MAX_KERNEL) + 1;
   localparam int COL_BITS  = $clog2(MAX_COLS);

   logic [10:0] in_rows_ff, in_cols_ff;
   logic [3:0]  kr_ff, kc_ff, sr_ff, sc_ff;
   logic [2:0]  pr_ff, pc_ff;
   logic        csr_write;
   axis_type    axis_r, axis_c;

   logic                   q_push, q_full, q_pop, q_valid;
   task_type               q_task, q_head;
   logic                   back_busy, older_busy;
   logic [SEQ_W-1:0]       back_seq, older_seq;
   logic                   wr_en;
   logic [SLOT_BITS-1:0]   wr_slot, rd_slot;
   logic [COL_BITS-1:0]    wr_col, rd_col;
   logic [SAMPLE_BITS-1:0] wr_data, rd_data, out_max;
   logic [OUT_IDX_W-1:0]   out_row, out_col;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_rows_ff <= 11'd1;  in_cols_ff <= 11'd1;
         kr_ff <= 4'd2;  kc_ff <= 4'd2;  sr_ff <= 4'd2;  sc_ff <= 4'd2;
         pr_ff <= 3'd0;  pc_ff <= 3'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CFG_IN_ROWS:     in_rows_ff <= csr_data;
            CFG_IN_COLS:     in_cols_ff <= csr_data;
            CFG_KERNEL_ROWS: kr_ff <= csr_data[3:0];
            CFG_KERNEL_COLS: kc_ff <= csr_data[3:0];
            CFG_STEP_ROWS:   sr_ff <= csr_data[3:0];
            CFG_STEP_COLS:   sc_ff <= csr_data[3:0];
            CFG_PAD_ROWS:    pr_ff <= csr_data[2:0];
            CFG_PAD_COLS:    pc_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // Clamp settings to their legal ranges.
   always_comb begin
      axis_r.n = (in_rows_ff == '0) ? AXIS_W'(1) :
                 (AXIS_W'(in_rows_ff) > AXIS_W'(MAX_ROWS)) ? AXIS_W'(MAX_ROWS) :
                 AXIS_W'(in_rows_ff);
      axis_c.n = (in_cols_ff == '0) ? AXIS_W'(1) :
                 (AXIS_W'(in_cols_ff) > AXIS_W'(MAX_COLS)) ? AXIS_W'(MAX_COLS) :
                 AXIS_W'(in_cols_ff);
      axis_r.k = (kr_ff == '0) ? KERN_W'(1) :
                 (KERN_W'(kr_ff) > KERN_W'(MAX_KERNEL)) ? KERN_W'(MAX_KERNEL) :
                 KERN_W'(kr_ff);
      axis_c.k = (kc_ff == '0) ? KERN_W'(1) :
                 (KERN_W'(kc_ff) > KERN_W'(MAX_KERNEL)) ? KERN_W'(MAX_KERNEL) :
                 KERN_W'(kc_ff);
      axis_r.s = (sr_ff == '0) ? STEP_W'(1) : sr_ff;
      axis_c.s = (sc_ff == '0) ? STEP_W'(1) : sc_ff;
      axis_r.p = (KERN_W'(pr_ff) >= axis_r.k) ? PAD_W'(axis_r.k - KERN_W'(1)) : pr_ff;
      axis_c.p = (KERN_W'(pc_ff) >= axis_c.k) ? PAD_W'(axis_c.k - KERN_W'(1)) : pc_ff;
   end

   // Oldest work that may still read the line store.
   assign older_busy = back_busy || q_valid;
   assign older_seq  = back_busy ? back_seq : q_head.seq;

   mp2d_front #(
      .SAMPLE_BITS(SAMPLE_BITS), .SLOT_BITS(SLOT_BITS),
      .COL_BITS(COL_BITS), .MAX_KERNEL(MAX_KERNEL)
   ) u_front (
      .clock(clock), .reset(reset), .restart(csr_write),
      .axis_r(axis_r), .axis_c(axis_c),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .sample(req_tdata[SAMPLE_BITS-1:0]),
      .q_full(q_full), .q_push(q_push), .q_task(q_task),
      .older_busy(older_busy), .older_seq(older_seq),
      .wr_en(wr_en), .wr_slot(wr_slot), .wr_col(wr_col), .wr_data(wr_data)
   );

   mp2d_task_fifo #(.DEPTH(4)) u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_task), .full(q_full),
      .pop(q_pop), .not_empty(q_valid), .head(q_head)
   );

   mp2d_line_store #(
      .SAMPLE_BITS(SAMPLE_BITS), .SLOT_BITS(SLOT_BITS), .COL_BITS(COL_BITS)
   ) u_store (
      .clock(clock),
      .wr_en(wr_en), .wr_slot(wr_slot), .wr_col(wr_col), .wr_data(wr_data),
      .rd_slot(rd_slot), .rd_col(rd_col), .rd_data(rd_data)
   );

   mp2d_back #(
      .SAMPLE_BITS(SAMPLE_BITS), .SLOT_BITS(SLOT_BITS), .COL_BITS(COL_BITS)
   ) u_back (
      .clock(clock), .reset(reset),
      .axis_r(axis_r), .axis_c(axis_c),
      .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
      .busy(back_busy), .busy_seq(back_seq),
      .rd_slot(rd_slot), .rd_col(rd_col), .rd_data(rd_data),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_max(out_max), .out_row(out_row), .out_col(out_col),
      .out_last(rsp_tlast), .out_done(rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({out_col, out_row, out_max});

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("run queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("run queue underflow");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast) else $error("plane end not run end");

endmodule

/* sv/mp2d_task_fifo.sv */
// mp2d_task_fifo: short queue of window runs between the front and back parts.
// Depends on mp2d_pkg (task_type).

module mp2d_task_fifo import mp2d_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  task_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output task_type head
);
   localparam int PTR_W = $clog2(DEPTH);

   task_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [PTR_W:0]      count_ff, count_in;

   assign full      = count_ff == (PTR_W+1)'(DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH-1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH-1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + (PTR_W+1)'(1);
      else if (pop && !push) count_in = count_ff - (PTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wptr_ff] <= push_data;
   end

endmodule

/* sv/mp2d_line_store.sv */
// mp2d_line_store: row ring of recent samples, one write and one registered read port.
// Depends on mp2d_pkg only for a parameter default (DEF_SAMPLE_BITS).

module mp2d_line_store import mp2d_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int SLOT_BITS   = 4,
   parameter int COL_BITS    = 10
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [SLOT_BITS-1:0]   wr_slot,
   input  logic [COL_BITS-1:0]    wr_col,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic [SLOT_BITS-1:0]   rd_slot,
   input  logic [COL_BITS-1:0]    rd_col,
   output logic [SAMPLE_BITS-1:0] rd_data
);
   localparam int DEPTH = (2 ** SLOT_BITS) * (2 ** COL_BITS);

   logic [SAMPLE_BITS-1:0] mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[{wr_slot, wr_col}] <= wr_data;
      rd_data_ff <= mem[{rd_slot, rd_col}];
   end

endmodule

/* sv/mp2d_front.sv */
// mp2d_front: accepts samples, tracks the plane position and the next window on each
// axis, writes the line store and queues the run of windows each sample completes.
// Depends on mp2d_pkg.

module mp2d_front import mp2d_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int SLOT_BITS   = 4,
   parameter int COL_BITS    = 10,
   parameter int MAX_KERNEL  = DEF_MAX_KERNEL
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  axis_type               axis_r,
   input  axis_type               axis_c,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic                   q_full,
   output logic                   q_push,
   output task_type               q_task,
   input  logic                   older_busy,
   input  logic [SEQ_W-1:0]       older_seq,
   output logic                   wr_en,
   output logic [SLOT_BITS-1:0]   wr_slot,
   output logic [COL_BITS-1:0]    wr_col,
   output logic [SAMPLE_BITS-1:0] wr_data
);
   logic [AXIS_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [AXIS_W-1:0] ro_ff, ro_in, rbeg_ff, rbeg_in;
   logic [AXIS_W-1:0] co_ff, co_in, cbeg_ff, cbeg_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [SEQ_W-1:0]  lag;
   logic              room, take, last_r, last_c, hit_r, hit_c, match_r, match_c;

   always_comb begin
      // Rows still being read by older work must not be overwritten.
      lag        = seq_ff - older_seq;
      room       = !older_busy || (lag < SEQ_W'(MAX_KERNEL));
      req_tready = !q_full && room;
      take       = req_tvalid && req_tready;

      last_r  = r_ff == axis_r.n - AXIS_W'(1);
      last_c  = c_ff == axis_c.n - AXIS_W'(1);
      hit_r   = win_end(axis_r, rbeg_ff) == r_ff;
      hit_c   = win_end(axis_c, cbeg_ff) == c_ff;
      match_r = win_ok(axis_r, rbeg_ff) && (hit_r || last_r);
      match_c = win_ok(axis_c, cbeg_ff) && (hit_c || last_c);

      q_push          = take && match_r && match_c;
      q_task.ro       = ro_ff;
      q_task.rbeg     = rbeg_ff;
      q_task.row_all  = last_r;
      q_task.co       = co_ff;
      q_task.cbeg     = cbeg_ff;
      q_task.col_all  = last_c;
      q_task.seq      = seq_ff;
      q_task.base     = seq_ff - r_ff[SEQ_W-1:0];

      wr_en   = take;
      wr_slot = seq_ff[SLOT_BITS-1:0];
      wr_col  = c_ff[COL_BITS-1:0];
      wr_data = sample;

      r_in = r_ff;  c_in = c_ff;  seq_in = seq_ff;
      ro_in = ro_ff;  rbeg_in = rbeg_ff;
      co_in = co_ff;  cbeg_in = cbeg_ff;
      if (restart) begin
         r_in = '0;  c_in = '0;
         ro_in = '0;  rbeg_in = '0;
         co_in = '0;  cbeg_in = '0;
      end else if (take) begin
         if (last_c) begin
            c_in    = '0;
            co_in   = '0;
            cbeg_in = '0;
            seq_in  = seq_ff + SEQ_W'(1);
            if (last_r) begin
               r_in    = '0;
               ro_in   = '0;
               rbeg_in = '0;
            end else begin
               r_in = r_ff + AXIS_W'(1);
               if (hit_r) begin
                  ro_in   = ro_ff + AXIS_W'(1);
                  rbeg_in = rbeg_ff + AXIS_W'(axis_r.s);
               end
            end
         end else begin
            c_in = c_ff + AXIS_W'(1);
            if (hit_c) begin
               co_in   = co_ff + AXIS_W'(1);
               cbeg_in = cbeg_ff + AXIS_W'(axis_c.s);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;  c_ff <= '0;  seq_ff <= '0;
         ro_ff <= '0;  rbeg_ff <= '0;
         co_ff <= '0;  cbeg_ff <= '0;
      end else begin
         r_ff <= r_in;  c_ff <= c_in;  seq_ff <= seq_in;
         ro_ff <= ro_in;  rbeg_ff <= rbeg_in;
         co_ff <= co_in;  cbeg_ff <= cbeg_in;
      end
   end

endmodule

/* sv/mp2d_back.sv */
// mp2d_back: walks each queued run of windows, reads every window element from the
// line store one per cycle, keeps the running maximum and registers the results.
// Depends on mp2d_pkg.

module mp2d_back import mp2d_pkg::*; #(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int SLOT_BITS   = 4,
   parameter int COL_BITS    = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  axis_type               axis_r,
   input  axis_type               axis_c,
   input  logic                   q_valid,
   input  task_type               q_head,
   output logic                   q_pop,
   output logic                   busy,
   output logic [SEQ_W-1:0]       busy_seq,
   output logic [SLOT_BITS-1:0]   rd_slot,
   output logic [COL_BITS-1:0]    rd_col,
   input  logic [SAMPLE_BITS-1:0] rd_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_max,
   output logic [OUT_IDX_W-1:0]   out_row,
   output logic [OUT_IDX_W-1:0]   out_col,
   output logic                   out_last,
   output logic                   out_done
);
   back_state_type state_ff, state_in;
   task_type       task_ff, task_in;
   logic [AXIS_W-1:0] ro_ff, ro_in, rbeg_ff, rbeg_in, co_ff, co_in, cbeg_ff, cbeg_in;
   logic [AXIS_W-1:0] y_ff, y_in, x_ff, x_in, r1_ff, r1_in, c0_ff, c0_in, c1_ff, c1_in;
   logic              first_ff, first_in;
   logic              rd_valid_ff, rd_first_ff;
   logic [SAMPLE_BITS-1:0] acc_ff;
   logic              ovalid_ff, ovalid_in;
   logic [SAMPLE_BITS-1:0] omax_ff;
   logic [OUT_IDX_W-1:0]   orow_ff, ocol_ff;
   logic              olast_ff, odone_ff, load_out;
   logic [AXIS_W-1:0] rnext, cnext;
   logic              col_more, row_more, row_end, col_end, slot_free;

   assign busy      = state_ff != BK_IDLE;
   assign busy_seq  = task_ff.seq;
   assign rd_slot   = SLOT_BITS'(task_ff.base + y_ff[SEQ_W-1:0]);
   assign rd_col    = x_ff[COL_BITS-1:0];
   assign out_valid = ovalid_ff;
   assign out_max   = omax_ff;
   assign out_row   = orow_ff;
   assign out_col   = ocol_ff;
   assign out_last  = olast_ff;
   assign out_done  = odone_ff;

   always_comb begin
      rnext     = rbeg_ff + AXIS_W'(axis_r.s);
      cnext     = cbeg_ff + AXIS_W'(axis_c.s);
      row_end   = !win_ok(axis_r, rnext);
      col_end   = !win_ok(axis_c, cnext);
      col_more  = task_ff.col_all && !col_end;
      row_more  = task_ff.row_all && !row_end;
      slot_free = !ovalid_ff || out_ready;

      state_in = state_ff;  task_in = task_ff;
      ro_in = ro_ff;  rbeg_in = rbeg_ff;  co_in = co_ff;  cbeg_in = cbeg_ff;
      y_in = y_ff;  x_in = x_ff;  r1_in = r1_ff;  c0_in = c0_ff;  c1_in = c1_ff;
      first_in = first_ff;
      q_pop    = 1'b0;
      load_out = 1'b0;
      ovalid_in = ovalid_ff && !out_ready;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               task_in  = q_head;
               ro_in    = q_head.ro;
               rbeg_in  = q_head.rbeg;
               co_in    = q_head.co;
               cbeg_in  = q_head.cbeg;
               state_in = BK_SETUP;
            end
         end
         BK_SETUP: begin
            y_in     = win_first(axis_r, rbeg_ff);
            r1_in    = win_last(axis_r, rbeg_ff);
            c0_in    = win_first(axis_c, cbeg_ff);
            x_in     = win_first(axis_c, cbeg_ff);
            c1_in    = win_last(axis_c, cbeg_ff);
            first_in = 1'b1;
            state_in = BK_READ;
         end
         BK_READ: begin
            first_in = 1'b0;
            if (x_ff == c1_ff) begin
               x_in = c0_ff;
               y_in = y_ff + AXIS_W'(1);
               if (y_ff == r1_ff) state_in = BK_DRAIN;
            end else begin
               x_in = x_ff + AXIS_W'(1);
            end
         end
         BK_DRAIN: begin
            state_in = BK_FINISH;
         end
         BK_FINISH: begin
            if (slot_free) begin
               load_out  = 1'b1;
               ovalid_in = 1'b1;
               if (col_more) begin
                  co_in    = co_ff + AXIS_W'(1);
                  cbeg_in  = cnext;
                  state_in = BK_SETUP;
               end else if (row_more) begin
                  ro_in    = ro_ff + AXIS_W'(1);
                  rbeg_in  = rnext;
                  co_in    = task_ff.co;
                  cbeg_in  = task_ff.cbeg;
                  state_in = BK_SETUP;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= BK_IDLE;
         ovalid_ff   <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ovalid_ff   <= ovalid_in;
         rd_valid_ff <= state_ff == BK_READ;
      end
   end

   always_ff @(posedge clock) begin
      task_ff <= task_in;
      ro_ff <= ro_in;  rbeg_ff <= rbeg_in;  co_ff <= co_in;  cbeg_ff <= cbeg_in;
      y_ff <= y_in;  x_ff <= x_in;  r1_ff <= r1_in;  c0_ff <= c0_in;  c1_ff <= c1_in;
      first_ff    <= first_in;
      rd_first_ff <= first_ff;
      if (rd_valid_ff) begin
         if (rd_first_ff || ($signed(rd_data) > $signed(acc_ff))) acc_ff <= rd_data;
      end
      if (load_out) begin
         omax_ff  <= acc_ff;
         orow_ff  <= ro_ff[OUT_IDX_W-1:0];
         ocol_ff  <= co_ff[OUT_IDX_W-1:0];
         olast_ff <= !col_more && !row_more;
         odone_ff <= row_end && col_end;
      end
   end

endmodule

/* tb/max_pool_2d_stream_tb.sv */
// max_pool_2d_stream_tb: self-checking testbench for the streaming 2-D max pool block.
// Drives random planes under several settings, predicts window maxima in a scoreboard.
// Depends on mp2d_pkg and max_pool_2d_stream.
`timescale 1ns / 1ps

class pool_scoreboard;
   // settings as written
   int unsigned rows_reg, cols_reg, krow_reg, kcol_reg, srow_reg, scol_reg, prow_reg, pcol_reg;
   int unsigned cur_row, cur_col;
   logic signed [15:0] plane_buf [0:7][0:1023];
   logic [39:0] pending_q [$];   // {plane_done, last, col, row, max}
   int errors;
   int checked;

   function void reset_state();
      rows_reg = 1; cols_reg = 1; krow_reg = 2; kcol_reg = 2;
      srow_reg = 2; scol_reg = 2; prow_reg = 0; pcol_reg = 0;
      cur_row = 0; cur_col = 0;
      pending_q.delete();
      errors = 0; checked = 0;
   endfunction

   function void write_reg(int unsigned idx, int unsigned value);
      int unsigned v;
      v = value & 11'h7ff;
      case (idx)
         mp2d_pkg::CFG_IN_ROWS:     rows_reg = v;
         mp2d_pkg::CFG_IN_COLS:     cols_reg = v;
         mp2d_pkg::CFG_KERNEL_ROWS: krow_reg = v & 4'hf;
         mp2d_pkg::CFG_KERNEL_COLS: kcol_reg = v & 4'hf;
         mp2d_pkg::CFG_STEP_ROWS:   srow_reg = v & 4'hf;
         mp2d_pkg::CFG_STEP_COLS:   scol_reg = v & 4'hf;
         mp2d_pkg::CFG_PAD_ROWS:    prow_reg = v & 3'h7;
         mp2d_pkg::CFG_PAD_COLS:    pcol_reg = v & 3'h7;
         default: ;
      endcase
      cur_row = 0; cur_col = 0;
   endfunction

   // clamps one axis; returns size, kernel, stride, pad and output count
   function void clamp_axis(int unsigned n_in, int unsigned k_in, int unsigned s_in,
                            int unsigned p_in, output int unsigned n, output int unsigned k,
                            output int unsigned s, output int unsigned p,
                            output int unsigned outn);
      n = (n_in == 0) ? 1 : (n_in > 1024 ? 1024 : n_in);
      k = (k_in == 0) ? 1 : (k_in > 8 ? 8 : k_in);
      s = (s_in == 0) ? 1 : s_in;
      p = (p_in >= k) ? k - 1 : p_in;
      outn = (n + 2 * p < k) ? 0 : (n + 2 * p - k) / s + 1;
   endfunction

   function int unsigned win_last(int unsigned o, int unsigned n, int unsigned k,
                                  int unsigned s, int unsigned p);
      int unsigned e;
      e = o * s + k - 1 - p;
      return (e > n - 1) ? n - 1 : e;
   endfunction

   function int unsigned win_first(int unsigned o, int unsigned s, int unsigned p);
      return (o * s >= p) ? o * s - p : 0;
   endfunction

   // windows finishing at index pos on one axis
   function void done_list(int unsigned pos, int unsigned n, int unsigned k, int unsigned s,
                           int unsigned p, int unsigned outn, ref int unsigned lst[$]);
      int unsigned t, o;
      t = k - 1 - p;
      o = (pos > t) ? (pos - t + s - 1) / s : 0;
      lst.delete();
      while (o < outn && lst.size() < 8 && win_last(o, n, k, s, p) == pos) begin
         lst.push_back(o);
         o++;
      end
   endfunction

   // notes one accepted sample and queues the window maxima it completes
   function int note_sample(logic signed [15:0] smp);
      int unsigned nr, kr, sr, pr, onr, nc, kc, sc, pc, onc;
      int unsigned rl[$], cl[$];
      int unsigned r, c;
      int produced;
      logic signed [15:0] best;
      logic [39:0] ent;
      clamp_axis(rows_reg, krow_reg, srow_reg, prow_reg, nr, kr, sr, pr, onr);
      clamp_axis(cols_reg, kcol_reg, scol_reg, pcol_reg, nc, kc, sc, pc, onc);
      r = cur_row; c = cur_col;
      if (r >= nr || c >= nc) begin
         r = 0; c = 0;
      end
      plane_buf[r % 8][c] = smp;
      done_list(r, nr, kr, sr, pr, onr, rl);
      done_list(c, nc, kc, sc, pc, onc, cl);
      produced = 0;
      foreach (rl[i]) begin
         foreach (cl[j]) begin
            best = plane_buf[win_first(rl[i], sr, pr) % 8][win_first(cl[j], sc, pc)];
            for (int y = win_first(rl[i], sr, pr); y <= win_last(rl[i], nr, kr, sr, pr); y++)
               for (int x = win_first(cl[j], sc, pc); x <= win_last(cl[j], nc, kc, sc, pc);
                    x++)
                  if (plane_buf[y % 8][x] > best) best = plane_buf[y % 8][x];
            ent = {(rl[i] == onr - 1 && cl[j] == onc - 1), 1'b0, 11'(cl[j]), 11'(rl[i]),
                   best};
            pending_q.push_back(ent);
            produced++;
         end
      end
      if (produced > 0) pending_q[pending_q.size() - 1][38] = 1'b1;
      c++;
      if (c >= nc) begin
         c = 0;
         r++;
         if (r >= nr) r = 0;
      end
      cur_row = r; cur_col = c;
      return produced;
   endfunction

   function void check_result(logic [15:0] mx, logic [10:0] orow, logic [10:0] ocol,
                              logic lst, logic pdone);
      logic [39:0] got, want;
      got = {pdone, lst, ocol, orow, mx};
      checked++;
      if (pending_q.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result %h", got);
         return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10)
            $display({"mismatch: exp max=%h row=%0d col=%0d last=%b done=%b, ",
                      "got max=%h row=%0d col=%0d last=%b done=%b"},
                     want[15:0], want[26:16], want[37:27], want[38], want[39],
                     mx, orow, ocol, lst, pdone);
      end
   endfunction
endclass

module max_pool_2d_stream_tb;
   import mp2d_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [15:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [39:0] rsp_tdata;
   logic rsp_tlast, rsp_tuser;
   logic csr_valid, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   pool_scoreboard board;
   int idle_cycles;
   int stall_mode;     // 0 random stalls, 1 never stall; any other value stalls at random
   int hold_count;
   int sample_total;
   int phase_total;

   max_pool_2d_stream dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: check and stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata[15:0], rsp_tdata[26:16], rsp_tdata[37:27],
                               rsp_tlast, rsp_tuser);
         if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            rsp_tready <= 1'b0;
         end else if (stall_mode == 1) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || hold_count > 0)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_csr(input cfg_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[10:0];
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [15:0] smp);
      int unsigned gap;
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      do @(posedge clock); while (!req_tready);
      void'(board.note_sample(smp));
      sample_total++;
      // bursts: usually keep valid high, now and then drop for a random gap
      if ($urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);   // back end may still be busy on a window
   endtask

   task automatic setup(input int unsigned r, input int unsigned c, input int unsigned kr,
                        input int unsigned kc, input int unsigned sr, input int unsigned sc,
                        input int unsigned pr, input int unsigned pc);
      write_csr(CFG_IN_ROWS, r);
      write_csr(CFG_IN_COLS, c);
      write_csr(CFG_KERNEL_ROWS, kr);
      write_csr(CFG_KERNEL_COLS, kc);
      write_csr(CFG_STEP_ROWS, sr);
      write_csr(CFG_STEP_COLS, sc);
      write_csr(CFG_PAD_ROWS, pr);
      write_csr(CFG_PAD_COLS, pc);
   endtask

   // random values biased to the extremes now and then
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_plane(input int unsigned count);
      repeat (count) send_sample(pick_sample());
   endtask

   initial begin
      board = new();
      board.reset_state();
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0; csr_index = CFG_IN_ROWS; csr_data = '0;
      stall_mode = 0; hold_count = 0; idle_cycles = 0;
      sample_total = 0; phase_total = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 1x1 plane with a 2x2 kernel gives no windows
      run_plane(3);
      drain();

      // directed: sample extremes, 2x2 stride 2 on 4x4
      setup(4, 4, 2, 2, 2, 2, 0, 0);
      send_sample(16'h8000); send_sample(16'h7fff); send_sample(16'h0000);
      send_sample(16'hffff);
      repeat (4) send_sample(16'h8000);
      send_sample(16'h5555); send_sample(16'haaaa); send_sample(16'h0001);
      send_sample(16'h8001);
      repeat (4) send_sample(16'h7ffe);
      drain();

      // zero size, zero kernel, zero stride, oversized padding, bad index
      setup(0, 0, 0, 0, 0, 0, 7, 7);
      run_plane(2);
      drain();
      write_csr(cfg_index_type'(4'hf), 11'h7ff);
      setup(3, 5, 15, 3, 1, 1, 7, 7);
      run_plane(15);
      drain();
      // largest plane width, stride equal to kernel, big padding
      setup(2, 1500, 8, 8, 8, 8, 7, 7);
      run_plane(40);
      drain();

      // long receiver hold-off: every sample yields a result, so the block backs up
      stall_mode = 0;
      setup(6, 6, 1, 1, 1, 1, 0, 0);
      hold_count = 300;
      run_plane(36);
      drain();

      // random phases
      phase_total = 0;
      while (sample_total < 230) begin
         int unsigned r, c, kr, kc, cnt;
         r = $urandom_range(1, 9);
         c = $urandom_range(1, 9);
         kr = $urandom_range(1, 8);
         kc = $urandom_range(1, 8);
         setup(r, c, kr, kc, $urandom_range(1, 8), $urandom_range(1, 8),
               $urandom_range(0, 7), $urandom_range(0, 7));
         stall_mode = $urandom_range(0, 1);
         if (phase_total == 1) hold_count = 300;
         cnt = r * c * $urandom_range(1, 2);
         if (cnt > 230 - sample_total) cnt = 230 - sample_total;
         run_plane(cnt);
         drain();
         phase_total++;
      end

      repeat (50) @(posedge clock);
      $display({"Ran %0d samples in %0d random setting phases plus directed edge cases ",
                "and a long output stall; %0d results checked."},
               sample_total, phase_total, board.checked);
      if (board.errors == 0 && board.pending_q.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
